>>> src/corlt_pkg.sv
package corlt_pkg;

    // Type-table index carried by every list position (tables have eight entries)
    localparam int unsigned LIST_MAX   = 8;
    localparam int unsigned TYPE_IDX_W = 3;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TECHNOLOGY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_MATE = 1'b1;

    // Technology codes
    localparam logic [1:0] TECH_SHORT = 2'd0;
    localparam logic [1:0] TECH_COLOR = 2'd1;
    localparam logic [1:0] TECH_LONG  = 2'd2;

    typedef enum logic [1:0] {
        MODE_GET     = 2'd0,
        MODE_SUCCESS = 2'd1,
        MODE_CLEAR   = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_IDLE  = 2'd0,
        OP_HIT   = 2'd1,
        OP_CLEAR = 2'd2
    } cell_op_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        cell_op_t              op;
        logic                  fwd;
        logic [TYPE_IDX_W-1:0] id;
    } cell_cmd_t;

    // Type code: bit 2 upstream, bit 1 seq_inverse, bit 0 seq_complement
    localparam logic [2:0] TAB_SHORT_FWD [LIST_MAX] = '{3'd7, 3'd3, 3'd4, 3'd0,
                                                         3'd5, 3'd1, 3'd2, 3'd6};
    localparam logic [2:0] TAB_SHORT_REV [LIST_MAX] = '{3'd0, 3'd4, 3'd3, 3'd7,
                                                         3'd2, 3'd6, 3'd5, 3'd1};
    localparam logic [2:0] TAB_ALT_FWD   [LIST_MAX] = '{3'd4, 3'd0, 3'd7, 3'd3,
                                                         3'd6, 3'd2, 3'd5, 3'd1};
    localparam logic [2:0] TAB_ALT_REV   [LIST_MAX] = '{3'd3, 3'd7, 3'd0, 3'd4,
                                                         3'd1, 3'd5, 3'd2, 3'd6};

    function automatic logic [2:0] type_code(
        input logic [1:0]            tech,
        input logic                  first_mate,
        input logic                  fwd,
        input logic [TYPE_IDX_W-1:0] idx
    );
        logic alt;
        logic mirror;
        alt    = 1'b0;
        mirror = 1'b0;
        unique case (tech)
            TECH_COLOR:
            begin
                alt    = first_mate;
                mirror = !first_mate;
            end
            TECH_LONG:
            begin
                alt    = !first_mate;
                mirror = first_mate;
            end
            default:
            begin
                alt    = 1'b0;
                mirror = 1'b0;
            end
        endcase
        if (alt)
        begin
            return fwd ? TAB_ALT_FWD[idx] : TAB_ALT_REV[idx];
        end
        // second arrangement swaps the short-read tables between directions
        if (fwd ^ mirror)
        begin
            return TAB_SHORT_FWD[idx];
        end
        return TAB_SHORT_REV[idx];
    endfunction

endpackage

>>> src/corlt_req_if.sv
interface corlt_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       anchor_forward;

    modport source (output valid, output mode, output anchor_forward, input ready);
    modport sink   (input valid, input mode, input anchor_forward, output ready);
endinterface

>>> src/corlt_rsp_if.sv
interface corlt_rsp_if;
    logic valid;
    logic ready;
    logic ok;
    logic upstream;
    logic seq_inverse;
    logic seq_complement;

    modport source (output valid, output ok, output upstream, output seq_inverse,
                    output seq_complement, input ready);
    modport sink   (input valid, input ok, input upstream, input seq_inverse,
                    input seq_complement, output ready);
endinterface

>>> src/corlt_cell.sv
// One list position for both lists: order entry and hit count.
// Trades contents with the left neighbor when its own count overtakes it.
module corlt_cell #(
    parameter int unsigned POS       = 0,
    parameter int unsigned HIT_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  corlt_pkg::cell_cmd_t             cmd,
    input  logic [HIT_WIDTH-1:0]             left_hits,
    input  logic [corlt_pkg::TYPE_IDX_W-1:0] left_order,
    input  logic                             right_swap,
    input  logic [HIT_WIDTH-1:0]             right_hits,
    input  logic [corlt_pkg::TYPE_IDX_W-1:0] right_order,
    output logic [HIT_WIDTH-1:0]             cur_hits,
    output logic [corlt_pkg::TYPE_IDX_W-1:0] cur_order,
    output logic [HIT_WIDTH-1:0]             inc_hits,
    output logic                             swap_up
);

    localparam logic [corlt_pkg::TYPE_IDX_W-1:0] POS_IDX = corlt_pkg::TYPE_IDX_W'(POS);

    logic [HIT_WIDTH-1:0]             fwd_hits_reg, fwd_hits_next;
    logic [HIT_WIDTH-1:0]             rev_hits_reg, rev_hits_next;
    logic [corlt_pkg::TYPE_IDX_W-1:0] fwd_order_reg, fwd_order_next;
    logic [corlt_pkg::TYPE_IDX_W-1:0] rev_order_reg, rev_order_next;

    logic                             target;
    logic [HIT_WIDTH-1:0]             new_hits;
    logic [corlt_pkg::TYPE_IDX_W-1:0] new_order;
    logic                             change;

    assign cur_hits  = cmd.fwd ? fwd_hits_reg  : rev_hits_reg;
    assign cur_order = cmd.fwd ? fwd_order_reg : rev_order_reg;
    assign inc_hits  = (cur_hits == {HIT_WIDTH{1'b1}}) ? cur_hits : cur_hits + 1'b1;
    assign target    = (cmd.op == corlt_pkg::OP_HIT) && (cmd.id == POS_IDX);
    // front position never moves
    assign swap_up   = target && (POS != 0) && (inc_hits > left_hits);

    always_comb
    begin
        new_hits  = cur_hits;
        new_order = cur_order;
        change    = 1'b0;
        if (swap_up)
        begin
            new_hits  = left_hits;
            new_order = left_order;
            change    = 1'b1;
        end
        else if (target)
        begin
            new_hits = inc_hits;
            change   = 1'b1;
        end
        else if (right_swap && (cmd.op == corlt_pkg::OP_HIT))
        begin
            new_hits  = right_hits;
            new_order = right_order;
            change    = 1'b1;
        end

        fwd_hits_next  = fwd_hits_reg;
        rev_hits_next  = rev_hits_reg;
        fwd_order_next = fwd_order_reg;
        rev_order_next = rev_order_reg;
        if (cmd.op == corlt_pkg::OP_CLEAR)
        begin
            fwd_hits_next  = '0;
            rev_hits_next  = '0;
            fwd_order_next = POS_IDX;
            rev_order_next = POS_IDX;
        end
        else if (change && cmd.fwd)
        begin
            fwd_hits_next  = new_hits;
            fwd_order_next = new_order;
        end
        else if (change)
        begin
            rev_hits_next  = new_hits;
            rev_order_next = new_order;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hits_reg  <= '0;
            rev_hits_reg  <= '0;
            fwd_order_reg <= POS_IDX;
            rev_order_reg <= POS_IDX;
        end
        else
        begin
            fwd_hits_reg  <= fwd_hits_next;
            rev_hits_reg  <= rev_hits_next;
            fwd_order_reg <= fwd_order_next;
            rev_order_reg <= rev_order_next;
        end
    end

endmodule

>>> src/count_ordered_region_type_list.sv
// Count-ordered region type lists, one for forward anchors, one for reverse.
// req channel: mode (get / success / clear) and anchor_forward pick the
// operation and the list. rsp channel: one transaction per request with ok
// and the three region flags (flags are zero unless a get hands out a type).
// cfg port: cfg_we, cfg_index, cfg_data select the type tables; write it
// only while no request is outstanding.
// The response is registered and shows in the cycle after the request
// transaction. The block takes one request per cycle while no response is
// held or the held one is taken; all work is done by the row of position
// cells, with the left-neighbor swap resolved between adjacent cells.
// When rsp stalls, req.ready drops while a response is held and comes back
// in the cycle the response is taken; no response is lost or repeated.
// Reset: lists return to identity order, hit counts and cursors clear,
// technology goes to short paired reads and first_mate to 1. No clearing
// pass is needed; the block takes requests right after reset.
module count_ordered_region_type_list #(
    parameter int unsigned NUM_TYPES = 6,
    parameter int unsigned HIT_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    corlt_req_if.sink                        req,
    corlt_rsp_if.source                      rsp,
    input  logic                             cfg_we,
    input  logic [corlt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [corlt_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned CUR_W = $clog2(NUM_TYPES + 1);
    localparam int unsigned IDX_W = $clog2(NUM_TYPES);
    localparam logic [CUR_W-1:0] CUR_END = CUR_W'(NUM_TYPES);

    logic [1:0]       tech_reg;
    logic             first_mate_reg;
    logic [CUR_W-1:0] fwd_cursor_reg, fwd_cursor_next;
    logic [CUR_W-1:0] rev_cursor_reg, rev_cursor_next;
    logic             fwd_taken_reg, fwd_taken_next;
    logic             rev_taken_reg, rev_taken_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             ok_reg, ok_next;
    logic [2:0]       code_reg, code_next;

    logic                             accept;
    corlt_pkg::mode_t                 mode;
    logic                             fwd;
    logic [CUR_W-1:0]                 cursor;
    logic [CUR_W-1:0]                 cursor_m1;
    logic                             taken;
    logic [CUR_W-1:0]                 cursor_upd;
    logic                             taken_upd;
    logic                             upd_sel;
    corlt_pkg::cell_cmd_t             cmd;
    logic [corlt_pkg::TYPE_IDX_W-1:0] pick_order;

    logic [HIT_WIDTH-1:0]             cur_hits  [NUM_TYPES];
    logic [corlt_pkg::TYPE_IDX_W-1:0] cur_order [NUM_TYPES];
    logic [HIT_WIDTH-1:0]             inc_hits  [NUM_TYPES];
    logic                             swap_up   [NUM_TYPES];

    assign req.ready          = !rsp_valid_reg || rsp.ready;
    assign accept             = req.valid && req.ready;
    assign mode               = corlt_pkg::mode_t'(req.mode);
    assign fwd                = req.anchor_forward;
    assign cursor             = fwd ? fwd_cursor_reg : rev_cursor_reg;
    assign taken              = fwd ? fwd_taken_reg : rev_taken_reg;
    assign cursor_m1          = cursor - 1'b1;
    assign pick_order         = cur_order[cursor[IDX_W-1:0]];

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.ok             = ok_reg;
    assign rsp.upstream       = code_reg[2];
    assign rsp.seq_inverse    = code_reg[1];
    assign rsp.seq_complement = code_reg[0];

    always_comb
    begin
        cmd.op     = corlt_pkg::OP_IDLE;
        cmd.fwd    = fwd;
        cmd.id     = corlt_pkg::TYPE_IDX_W'(cursor_m1);
        cursor_upd = cursor;
        taken_upd  = taken;
        upd_sel    = 1'b0;
        ok_next    = 1'b0;
        code_next  = 3'd0;
        unique case (mode)
            corlt_pkg::MODE_GET:
            begin
                upd_sel = 1'b1;
                if (cursor == CUR_END)
                begin
                    taken_upd = 1'b0;
                end
                else
                begin
                    cursor_upd = cursor + 1'b1;
                    taken_upd  = 1'b1;
                    ok_next    = 1'b1;
                    code_next  = corlt_pkg::type_code(tech_reg, first_mate_reg, fwd,
                                                      pick_order);
                end
            end
            corlt_pkg::MODE_SUCCESS:
            begin
                if (taken && (cursor != '0))
                begin
                    cmd.op     = corlt_pkg::OP_HIT;
                    upd_sel    = 1'b1;
                    cursor_upd = '0;
                    taken_upd  = 1'b0;
                    ok_next    = 1'b1;
                end
            end
            corlt_pkg::MODE_CLEAR:
            begin
                cmd.op = corlt_pkg::OP_CLEAR;
            end
            default:
            begin
                cmd.op = corlt_pkg::OP_IDLE;
            end
        endcase
        if (!accept)
        begin
            cmd.op  = corlt_pkg::OP_IDLE;
            upd_sel = 1'b0;
        end

        fwd_cursor_next = fwd_cursor_reg;
        rev_cursor_next = rev_cursor_reg;
        fwd_taken_next  = fwd_taken_reg;
        rev_taken_next  = rev_taken_reg;
        if (cmd.op == corlt_pkg::OP_CLEAR)
        begin
            fwd_cursor_next = '0;
            rev_cursor_next = '0;
            fwd_taken_next  = 1'b0;
            rev_taken_next  = 1'b0;
        end
        else if (upd_sel && fwd)
        begin
            fwd_cursor_next = cursor_upd;
            fwd_taken_next  = taken_upd;
        end
        else if (upd_sel)
        begin
            rev_cursor_next = cursor_upd;
            rev_taken_next  = taken_upd;
        end

        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_TYPES; g++)
        begin : g_cell
            logic [HIT_WIDTH-1:0]             left_hits;
            logic [corlt_pkg::TYPE_IDX_W-1:0] left_order;
            logic                             right_swap;
            logic [HIT_WIDTH-1:0]             right_hits;
            logic [corlt_pkg::TYPE_IDX_W-1:0] right_order;

            if (g == 0)
            begin : g_head
                assign left_hits  = {HIT_WIDTH{1'b1}};
                assign left_order = '0;
            end
            else
            begin : g_body
                assign left_hits  = cur_hits[g-1];
                assign left_order = cur_order[g-1];
            end

            if (g == NUM_TYPES - 1)
            begin : g_tail
                assign right_swap  = 1'b0;
                assign right_hits  = '0;
                assign right_order = '0;
            end
            else
            begin : g_link
                assign right_swap  = swap_up[g+1];
                assign right_hits  = inc_hits[g+1];
                assign right_order = cur_order[g+1];
            end

            corlt_cell #(
                .POS       (g),
                .HIT_WIDTH (HIT_WIDTH)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .left_hits   (left_hits),
                .left_order  (left_order),
                .right_swap  (right_swap),
                .right_hits  (right_hits),
                .right_order (right_order),
                .cur_hits    (cur_hits[g]),
                .cur_order   (cur_order[g]),
                .inc_hits    (inc_hits[g]),
                .swap_up     (swap_up[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tech_reg       <= corlt_pkg::TECH_SHORT;
            first_mate_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                corlt_pkg::REG_TECHNOLOGY: tech_reg       <= cfg_data;
                corlt_pkg::REG_FIRST_MATE: first_mate_reg <= cfg_data[0];
                default:                   tech_reg       <= tech_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_cursor_reg <= '0;
            rev_cursor_reg <= '0;
            fwd_taken_reg  <= 1'b0;
            rev_taken_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            fwd_cursor_reg <= fwd_cursor_next;
            rev_cursor_reg <= rev_cursor_next;
            fwd_taken_reg  <= fwd_taken_next;
            rev_taken_reg  <= rev_taken_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg   <= ok_next;
            code_reg <= code_next;
        end
    end

endmodule

>>> src/corlt_checker.sv
module corlt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic [1:0] req_mode,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_ok,
    input logic       rsp_upstream,
    input logic       rsp_seq_inverse,
    input logic       rsp_seq_complement
);

    logic req_xfer;
    logic rsp_flags;

    assign req_xfer  = req_valid && req_ready;
    assign rsp_flags = rsp_upstream || rsp_seq_inverse || rsp_seq_complement;

    // a held response keeps valid until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // every request produces a response on the next cycle
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> rsp_valid)
        else $error("no response after request transaction");

    // requests are only blocked by an untaken response
    a_ready_block: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request blocked without pending response");

    a_flags_zero: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && (req_mode != corlt_pkg::MODE_GET) |=> !rsp_flags)
        else $error("region flags set on a non-get response");

    a_clear_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && (req_mode == corlt_pkg::MODE_CLEAR) |=> !rsp_ok)
        else $error("clear request answered with ok");

endmodule

bind count_ordered_region_type_list corlt_checker u_corlt_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .req_mode           (req.mode),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_ok             (rsp.ok),
    .rsp_upstream       (rsp.upstream),
    .rsp_seq_inverse    (rsp.seq_inverse),
    .rsp_seq_complement (rsp.seq_complement)
);

>>> bench/count_ordered_region_type_list_tb.sv
module count_ordered_region_type_list_tb;

    localparam int unsigned NUM_TYPES   = 6;
    localparam int unsigned HIT_W       = 16;
    localparam int          CYCLE_LIMIT = 2000000;
    localparam int          HOLD_CYCLES = 200;
    localparam int          PHASE_ITEMS = 140;
    localparam int          DIR_ROWS    = 22;
    localparam logic [1:0]  TECH_UNKNOWN = 2'd3;

    typedef struct packed {
        corlt_pkg::mode_t mode;
        logic             fwd;
    } region_req_t;

    typedef struct packed {
        logic ok;
        logic upstream;
        logic seq_inverse;
        logic seq_complement;
    } region_rsp_t;

    typedef struct packed {
        corlt_pkg::mode_t mode;
        logic             fwd;
        logic             typed;
        region_rsp_t      want;
    } directed_row_t;

    // {technology, first_mate} per phase; the unknown technology falls back to short reads
    localparam logic [2:0] TABLE_SETTINGS [8] = '{
        {corlt_pkg::TECH_SHORT, 1'b0}, {corlt_pkg::TECH_COLOR, 1'b1},
        {corlt_pkg::TECH_COLOR, 1'b0}, {corlt_pkg::TECH_LONG, 1'b1},
        {corlt_pkg::TECH_LONG, 1'b0},  {TECH_UNKNOWN, 1'b1},
        {TECH_UNKNOWN, 1'b0},          {corlt_pkg::TECH_SHORT, 1'b1}
    };

    // Typed expectations assume the reset tables (short reads, first mate)
    directed_row_t directed_rows [DIR_ROWS] = '{
        '{corlt_pkg::MODE_SUCCESS, 1'b1, 1'b1, 4'b0000},   // success with nothing taken
        '{corlt_pkg::MODE_NONE,    1'b1, 1'b1, 4'b0000},
        '{corlt_pkg::MODE_GET,     1'b1, 1'b1, 4'b1111},
        '{corlt_pkg::MODE_GET,     1'b0, 1'b1, 4'b1000},
        '{corlt_pkg::MODE_GET,     1'b1, 1'b0, 4'b0000},
        '{corlt_pkg::MODE_GET,     1'b1, 1'b0, 4'b0000},
        '{corlt_pkg::MODE_GET,     1'b1, 1'b0, 4'b0000},
        '{corlt_pkg::MODE_GET,     1'b1, 1'b0, 4'b0000},
        '{corlt_pkg::MODE_GET,     1'b1, 1'b0, 4'b0000},
        '{corlt_pkg::MODE_GET,     1'b1, 1'b1, 4'b0000},   // forward list exhausted
        '{corlt_pkg::MODE_SUCCESS, 1'b1, 1'b1, 4'b0000},   // exhaustion dropped taken flag
        '{corlt_pkg::MODE_GET,     1'b0, 1'b0, 4'b0000},
        '{corlt_pkg::MODE_SUCCESS, 1'b0, 1'b1, 4'b1000},   // second position overtakes front
        '{corlt_pkg::MODE_GET,     1'b0, 1'b0, 4'b0000},
        '{corlt_pkg::MODE_SUCCESS, 1'b0, 1'b1, 4'b1000},   // front position stays put
        '{corlt_pkg::MODE_GET,     1'b0, 1'b0, 4'b0000},
        '{corlt_pkg::MODE_CLEAR,   1'b1, 1'b1, 4'b0000},
        '{corlt_pkg::MODE_GET,     1'b0, 1'b1, 4'b1000},
        '{corlt_pkg::MODE_SUCCESS, 1'b1, 1'b1, 4'b0000},
        '{corlt_pkg::MODE_NONE,    1'b0, 1'b1, 4'b0000},
        '{corlt_pkg::MODE_SUCCESS, 1'b0, 1'b1, 4'b1000},   // unknown mode left taken alone
        '{corlt_pkg::MODE_GET,     1'b0, 1'b1, 4'b1000}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic                             cfg_we;
    logic [corlt_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [corlt_pkg::CFG_DATA_W-1:0] cfg_data;

    corlt_req_if req_ch();
    corlt_rsp_if rsp_ch();

    // Shadow of the block: index 1 is the forward list, 0 the reverse list
    logic [corlt_pkg::TYPE_IDX_W-1:0] list_order  [2][NUM_TYPES];
    logic [HIT_W-1:0]                 hit_count   [2][NUM_TYPES];
    int unsigned                      list_cursor [2];
    bit                               list_taken  [2];
    logic [1:0]                       model_tech;
    logic                             model_first_mate;

    region_rsp_t expected_rsp_q [$];

    bit calm;
    bit long_hold;
    int failures;
    int cycle_count;
    int responses_checked;
    int requests_sent;
    int types_given;
    int exhausted_gets;
    int hits_counted;

    count_ordered_region_type_list #(
        .NUM_TYPES(NUM_TYPES),
        .HIT_WIDTH(HIT_W)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("count_ordered_region_type_list test failed");
            $finish;
        end
    end

    function automatic void clear_lists();
        for (int l = 0; l < 2; l++)
        begin
            for (int p = 0; p < NUM_TYPES; p++)
            begin
                list_order[l][p] = corlt_pkg::TYPE_IDX_W'(p);
                hit_count[l][p]  = '0;
            end
            list_cursor[l] = 0;
            list_taken[l]  = 1'b0;
        end
    endfunction

    function automatic logic [2:0] region_code(input logic fwd,
                                               input logic [corlt_pkg::TYPE_IDX_W-1:0] idx);
        logic use_alt;
        logic swap_dir;
        use_alt  = 1'b0;
        swap_dir = 1'b0;
        if (model_tech == corlt_pkg::TECH_COLOR)
        begin
            use_alt  = model_first_mate;
            swap_dir = !model_first_mate;
        end
        else if (model_tech == corlt_pkg::TECH_LONG)
        begin
            use_alt  = !model_first_mate;
            swap_dir = model_first_mate;
        end
        if (use_alt)
            return fwd ? corlt_pkg::TAB_ALT_FWD[idx] : corlt_pkg::TAB_ALT_REV[idx];
        if (fwd != swap_dir)
            return corlt_pkg::TAB_SHORT_FWD[idx];
        return corlt_pkg::TAB_SHORT_REV[idx];
    endfunction

    function automatic region_rsp_t predict_region_type(input region_req_t it);
        int unsigned                      l;
        int unsigned                      id;
        logic [HIT_W-1:0]                 held_hits;
        logic [corlt_pkg::TYPE_IDX_W-1:0] held_idx;
        region_rsp_t                      r;
        r = '0;
        l = it.fwd ? 1 : 0;
        case (it.mode)
            corlt_pkg::MODE_GET:
            begin
                if (list_cursor[l] >= NUM_TYPES)
                    list_taken[l] = 1'b0;
                else
                begin
                    r = {1'b1, region_code(it.fwd, list_order[l][list_cursor[l]])};
                    list_cursor[l]++;
                    list_taken[l] = 1'b1;
                end
            end
            corlt_pkg::MODE_SUCCESS:
            begin
                if (list_taken[l] && list_cursor[l] >= 1)
                begin
                    id = list_cursor[l] - 1;
                    if (hit_count[l][id] != '1)
                        hit_count[l][id]++;
                    // count transpose: overtake the left neighbor on a strictly higher count
                    if (id != 0 && hit_count[l][id] > hit_count[l][id-1])
                    begin
                        held_hits            = hit_count[l][id];
                        held_idx             = list_order[l][id];
                        hit_count[l][id]     = hit_count[l][id-1];
                        list_order[l][id]    = list_order[l][id-1];
                        hit_count[l][id-1]   = held_hits;
                        list_order[l][id-1]  = held_idx;
                    end
                    list_cursor[l] = 0;
                    list_taken[l]  = 1'b0;
                    r.ok = 1'b1;
                end
            end
            corlt_pkg::MODE_CLEAR:
                clear_lists();
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic send_request(input corlt_pkg::mode_t mode, input logic fwd, input bit typed,
                                input region_rsp_t want);
        int          gap;
        region_req_t it;
        region_rsp_t pred;
        it  = '{mode, fwd};
        gap = calm ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.mode           <= mode;
        req_ch.anchor_forward <= fwd;
        do @(posedge clk); while (!req_ch.ready);
        pred = predict_region_type(it);
        expected_rsp_q.push_back(typed ? want : pred);
        requests_sent++;
        if (mode == corlt_pkg::MODE_GET && pred.ok)
            types_given++;
        if (mode == corlt_pkg::MODE_GET && !pred.ok)
            exhausted_gets++;
        if (mode == corlt_pkg::MODE_SUCCESS && pred.ok)
            hits_counted++;
    endtask

    task automatic drain_responses();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // Only called with the block idle; both registers go in back to back
    task automatic program_tables(input logic [1:0] tech, input logic fm);
        logic spare;
        spare = 1'($urandom_range(0, 1));
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= corlt_pkg::REG_TECHNOLOGY;
        cfg_data  <= tech;
        @(negedge clk);
        cfg_index <= corlt_pkg::REG_FIRST_MATE;
        cfg_data  <= {spare, fm};
        @(negedge clk);
        cfg_we <= 1'b0;
        model_tech       = tech;
        model_first_mate = fm;
    endtask

    // Mostly get runs ended by a success, with some noise and the odd clear
    task automatic run_random_traffic(input int n);
        int   target;
        int   r;
        int   k;
        logic fwd;
        target = requests_sent + n;
        while (requests_sent < target)
        begin
            calm = ($urandom_range(0, 4) == 0);
            r    = $urandom_range(0, 99);
            fwd  = 1'($urandom_range(0, 1));
            if (r < 8)
                send_request(corlt_pkg::mode_t'($urandom_range(0, 3)), fwd, 1'b0, '0);
            else if (r < 10)
                send_request(corlt_pkg::MODE_CLEAR, fwd, 1'b0, '0);
            else
            begin
                k = $urandom_range(1, 7);
                repeat (k)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_request(corlt_pkg::MODE_GET, !fwd, 1'b0, '0);
                    send_request(corlt_pkg::MODE_GET, fwd, 1'b0, '0);
                end
                if ($urandom_range(0, 99) < 85)
                    send_request(corlt_pkg::MODE_SUCCESS, fwd, 1'b0, '0);
            end
        end
        calm = 1'b0;
    endtask

    // Response side: random stalls, one long hold-off on request
    initial
    begin
        int          stall;
        region_rsp_t got;
        region_rsp_t want;
        string       field_names [4];
        field_names  = '{"ok", "upstream", "seq_inverse", "seq_complement"};
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
            end
            stall = calm ? 0 : $urandom_range(0, 19);
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            got = {rsp_ch.ok, rsp_ch.upstream, rsp_ch.seq_inverse, rsp_ch.seq_complement};
            if (expected_rsp_q.size() == 0)
            begin
                $error("response transaction with no expectation waiting");
                failures++;
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                responses_checked++;
                for (int i = 0; i < 4; i++)
                begin
                    if (got[3-i] !== want[3-i])
                    begin
                        $error("%s: expected %0d, got %0d", field_names[i], want[3-i],
                               got[3-i]);
                        failures++;
                    end
                end
            end
        end
    end

    initial
    begin
        req_ch.valid          = 1'b0;
        req_ch.mode           = corlt_pkg::MODE_GET;
        req_ch.anchor_forward = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = corlt_pkg::REG_TECHNOLOGY;
        cfg_data  = '0;
        calm      = 1'b0;
        long_hold = 1'b0;
        clear_lists();
        model_tech       = corlt_pkg::TECH_SHORT;
        model_first_mate = 1'b1;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_request(directed_rows[i].mode, directed_rows[i].fwd,
                         directed_rows[i].typed, directed_rows[i].want);
        drain_responses();

        for (int p = 0; p < 8; p++)
        begin
            program_tables(TABLE_SETTINGS[p][2:1], TABLE_SETTINGS[p][0]);
            if (p == 3)
                long_hold = 1'b1;
            run_random_traffic(PHASE_ITEMS);
            drain_responses();
        end
        repeat (4) @(posedge clk);

        $display("%0d requests, %0d responses checked: %0d types handed out, %0d exhausted gets",
                 requests_sent, responses_checked, types_given, exhausted_gets);
        $display("%0d hits, every technology/mate table choice, %0d-cycle receiver hold-off",
                 hits_counted, HOLD_CYCLES);
        if (failures == 0)
            $display("count_ordered_region_type_list test passed");
        else
            $display("count_ordered_region_type_list test failed");
        $finish;
    end

endmodule
